/* rtl/core/bpfa_pkg.sv */
// Bitmap page frame allocator: shared types, codes and default sizes.
// No dependencies; the adder, the allocator top and the testbench import this package.
`default_nettype none

package bpfa_pkg;

    localparam int ADDR_W    = 56;
    localparam int CNT_OUT_W = 13;
    localparam int ALU_W     = ADDR_W + 2;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_PAGES  = 4096;
    localparam int DEF_PAGE_SHIFT = 12;
    localparam int DEF_WORD_BITS  = 32;

    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'd1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] page_address;
    } t_in_beat;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_W-1:0]    granted_address;
        logic [CNT_OUT_W-1:0] free_count;
        logic [CNT_OUT_W-1:0] total_count;
    } t_out_beat;

endpackage

`default_nettype wire

/* rtl/core/bpfa_addsub.sv */
// Shared address adder/subtractor, reused by the init, grant and free-check sequencer steps.
// Depends on bpfa_pkg for the datapath width.
`default_nettype none

module bpfa_addsub (
    input  wire logic [bpfa_pkg::ALU_W-1:0] i_a,
    input  wire logic [bpfa_pkg::ALU_W-1:0] i_b,
    input  wire logic                       i_sub,
    output logic      [bpfa_pkg::ALU_W-1:0] o_sum
);
    import bpfa_pkg::*;

    logic [ALU_W-1:0] b_op;

    assign b_op  = i_sub ? ~i_b : i_b;
    assign o_sum = i_a + b_op + ALU_W'(i_sub);

endmodule

`default_nettype wire

/* rtl/core/bpfa_bitmap.sv */
// Used-bit store: one write port, one read port with registered data.
// No package dependencies.
`default_nettype none

module bpfa_bitmap #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bpfa_word_scan.sv */
// Per-word range mask and lowest-free-bit search, shared by alloc and clear.
// No package dependencies.
`default_nettype none

module bpfa_word_scan #(
    parameter int WORD_BITS = 32,
    parameter int CNT_W     = 13,
    parameter int BIT_W     = 5
) (
    input  wire logic [WORD_BITS-1:0] i_word,
    input  wire logic [CNT_W-1:0]     i_left,
    output logic      [WORD_BITS-1:0] o_range_mask,
    output logic                      o_hit,
    output logic      [BIT_W-1:0]     o_bit
);

    logic [WORD_BITS-1:0] free_bits;

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            o_range_mask[j] = (int'(i_left) > j);
        end
    end

    assign free_bits = ~i_word & o_range_mask;
    assign o_hit     = |free_bits;

    always_comb begin
        o_bit = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (free_bits[j]) begin
                o_bit = BIT_W'(j);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bitmap_page_frame_allocator_top.sv */
// Bitmap page frame allocator, first fit; sequencer around a shared adder.
// Init clears one bitmap word a cycle; alloc scans for the first free bit; free checks
// the address, then reads and clears its bit; op 3 gets a bad-address status. One item at a time.
// Reset clears counts, bounds and region registers; bitmap contents stay undefined
// until the first init, which writes every word; no access reaches them before.
// Depends on bpfa_pkg, bpfa_addsub, bpfa_bitmap and bpfa_word_scan.
`default_nettype none

module bitmap_page_frame_allocator_top #(
    parameter int MAX_PAGES  = bpfa_pkg::DEF_MAX_PAGES,
    parameter int PAGE_SHIFT = bpfa_pkg::DEF_PAGE_SHIFT,
    parameter int WORD_BITS  = bpfa_pkg::DEF_WORD_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [bpfa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bpfa_pkg::ADDR_W-1:0]    i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire bpfa_pkg::t_in_beat             i_in_beat,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output bpfa_pkg::t_out_beat                 o_out_beat
);
    import bpfa_pkg::*;

    localparam int NUM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int CNT_W     = $clog2(MAX_PAGES + 1);
    localparam int MW        = CNT_W + PAGE_SHIFT + 1;
    localparam int DIV_SH    = CNT_W + 7;
    localparam longint unsigned RECIP = ((64'd1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W   = DIV_SH + 1;
    localparam int PROD_W    = CNT_W + RECIP_W;
    localparam logic [ALU_W-1:0] PAGE_MASK = (ALU_W'(1) << PAGE_SHIFT) - ALU_W'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT0, S_INIT1, S_INIT2, S_CLEAR, S_ASTART, S_SCAN, S_GRANT,
        S_FREE0, S_FREE1, S_FREE2, S_FREE3, S_FREE4, S_DONE
    } t_state;

    t_state               r_state;
    logic [ADDR_W-1:0]    r_start;
    logic [ADDR_W-1:0]    r_end;
    logic [ADDR_W-1:0]    r_base;
    logic [ADDR_W-1:0]    r_limit;
    logic [CNT_W-1:0]     r_total;
    logic [CNT_W-1:0]     r_free;
    logic [ADDR_W-1:0]    r_addr;
    logic [ALU_W-1:0]     r_lo;
    logic [ALU_W-1:0]     r_hi;
    logic [ALU_W-1:0]     r_off;
    logic                 r_bad;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_left;
    logic [CNT_W-1:0]     r_pbase;
    logic [CNT_W-1:0]     r_gidx;
    logic [CNT_W-1:0]     r_page;
    logic [WIDX_W-1:0]    r_cidx;
    logic [WIDX_W-1:0]    r_q;
    logic [BIT_W-1:0]     r_bit;
    logic [STATUS_W-1:0]  r_status;
    logic [ADDR_W-1:0]    r_granted;
    logic                 r_out_valid;
    t_out_beat            r_out_beat;

    logic [ALU_W-1:0]     alu_a;
    logic [ALU_W-1:0]     alu_b;
    logic                 alu_sub;
    logic [ALU_W-1:0]     alu_sum;
    logic [ALU_W-1:0]     raw_pages;
    logic [CNT_W-1:0]     n_total;
    logic                 region_empty;
    logic [MW-1:0]        meta_bytes;
    logic [MW-1:0]        meta_raw;
    logic [CNT_W-1:0]     n_meta;
    logic [PROD_W-1:0]    div_prod;
    logic [CNT_W-1:0]     word_first;
    logic [CNT_W-1:0]     scan_left;
    logic [WORD_BITS-1:0] range_mask;
    logic                 scan_hit;
    logic [BIT_W-1:0]     scan_bit;
    logic                 last_rel;
    logic                 last_word;
    logic                 free_bit;
    logic                 wr_en;
    logic [WIDX_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [WIDX_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic                 out_load;

    bpfa_addsub u_addsub (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    bpfa_bitmap #(
        .DEPTH  (NUM_WORDS),
        .WIDTH  (WORD_BITS),
        .ADDR_W (WIDX_W)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bpfa_word_scan #(
        .WORD_BITS (WORD_BITS),
        .CNT_W     (CNT_W),
        .BIT_W     (BIT_W)
    ) u_scan (
        .i_word       (rd_data),
        .i_left       (scan_left),
        .o_range_mask (range_mask),
        .o_hit        (scan_hit),
        .o_bit        (scan_bit)
    );

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_INIT0: begin
                alu_a = ALU_W'(r_start);
                alu_b = PAGE_MASK;
            end
            S_INIT1: begin
                alu_a   = r_hi;
                alu_b   = r_lo;
                alu_sub = 1'b1;
            end
            S_INIT2: begin
                alu_a = ALU_W'(r_base);
                alu_b = ALU_W'(r_total) << PAGE_SHIFT;
            end
            S_GRANT: begin
                alu_a = ALU_W'(r_base);
                alu_b = ALU_W'(r_gidx) << PAGE_SHIFT;
            end
            S_FREE0: begin
                alu_a   = ALU_W'(r_addr);
                alu_b   = ALU_W'(r_base);
                alu_sub = 1'b1;
            end
            S_FREE1: begin
                alu_a   = ALU_W'(r_addr);
                alu_b   = ALU_W'(r_limit);
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    assign raw_pages    = alu_sum >> PAGE_SHIFT;
    assign region_empty = alu_sum[ALU_W-1] || (alu_sum == '0);
    assign n_total      = (raw_pages > ALU_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                          : raw_pages[CNT_W-1:0];

    assign meta_bytes = (MW'(r_total) + MW'(7)) >> 3;
    assign meta_raw   = (meta_bytes + MW'((1 << PAGE_SHIFT) - 1)) >> PAGE_SHIFT;
    assign n_meta     = (meta_raw > MW'(r_total)) ? r_total : meta_raw[CNT_W-1:0];

    assign div_prod   = PROD_W'(r_page) * PROD_W'(RECIP);
    assign word_first = CNT_W'(int'(r_q) * WORD_BITS);

    assign scan_left = (r_state == S_CLEAR) ? r_rem : r_left;
    assign last_rel  = (int'(r_left) <= WORD_BITS);
    assign last_word = (r_cidx == WIDX_W'(NUM_WORDS - 1));
    assign free_bit  = rd_data[r_bit];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cidx;
        wr_data = range_mask;
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_ASTART: begin
                rd_en = (r_total != '0);
            end
            S_SCAN: begin
                wr_en   = scan_hit;
                wr_data = rd_data | (WORD_BITS'(1) << scan_bit);
                rd_en   = !scan_hit && !last_rel;
                rd_addr = r_cidx + WIDX_W'(1);
            end
            S_FREE3: begin
                rd_en   = 1'b1;
                rd_addr = r_q;
            end
            S_FREE4: begin
                wr_en   = free_bit;
                wr_addr = r_q;
                wr_data = rd_data & ~(WORD_BITS'(1) << r_bit);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_start     <= '0;
            r_end       <= '0;
            r_base      <= '0;
            r_limit     <= '0;
            r_total     <= '0;
            r_free      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_REGION_START: r_start <= i_cfg_data;
                    CFG_REGION_END:   r_end   <= i_cfg_data;
                endcase
            end

            if (out_load) begin
                r_out_valid                <= 1'b1;
                r_out_beat.status          <= r_status;
                r_out_beat.granted_address <= r_granted;
                r_out_beat.free_count      <= CNT_OUT_W'(r_free);
                r_out_beat.total_count     <= CNT_OUT_W'(r_total);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_addr    <= i_in_beat.page_address;
                        r_status  <= ST_OK;
                        r_granted <= '0;
                        unique case (i_in_beat.op)
                            OP_INIT:  r_state <= S_INIT0;
                            OP_ALLOC: r_state <= S_ASTART;
                            OP_FREE:  r_state <= S_FREE0;
                            default: begin
                                r_status <= ST_BAD_ADDR;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_INIT0: begin
                    r_lo    <= alu_sum & ~PAGE_MASK;
                    r_hi    <= ALU_W'(r_end) & ~PAGE_MASK;
                    r_state <= S_INIT1;
                end
                S_INIT1: begin
                    r_total <= region_empty ? '0 : n_total;
                    r_base  <= region_empty ? '0 : r_lo[ADDR_W-1:0];
                    r_state <= S_INIT2;
                end
                S_INIT2: begin
                    r_limit <= alu_sum[ADDR_W-1:0];
                    r_rem   <= n_meta;
                    r_free  <= r_total - n_meta;
                    r_cidx  <= '0;
                    r_state <= S_CLEAR;
                end
                S_CLEAR: begin
                    r_rem  <= (int'(r_rem) > WORD_BITS) ? CNT_W'(int'(r_rem) - WORD_BITS)
                                                        : '0;
                    r_cidx <= r_cidx + WIDX_W'(1);
                    if (last_word) begin
                        r_state <= S_DONE;
                    end
                end
                S_ASTART: begin
                    r_cidx  <= '0;
                    r_left  <= r_total;
                    r_pbase <= '0;
                    if (r_total == '0) begin
                        r_status <= ST_NO_FREE;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        r_gidx  <= r_pbase + CNT_W'(scan_bit);
                        r_state <= S_GRANT;
                    end else if (last_rel) begin
                        r_status <= ST_NO_FREE;
                        r_state  <= S_DONE;
                    end else begin
                        r_left  <= CNT_W'(int'(r_left) - WORD_BITS);
                        r_pbase <= CNT_W'(int'(r_pbase) + WORD_BITS);
                        r_cidx  <= r_cidx + WIDX_W'(1);
                    end
                end
                S_GRANT: begin
                    r_granted <= alu_sum[ADDR_W-1:0];
                    if (r_free != '0) begin
                        r_free <= r_free - CNT_W'(1);
                    end
                    r_state <= S_DONE;
                end
                S_FREE0: begin
                    r_off   <= alu_sum;
                    r_bad   <= alu_sum[ALU_W-1] || (r_addr[PAGE_SHIFT-1:0] != '0);
                    r_state <= S_FREE1;
                end
                S_FREE1: begin
                    if (r_bad || !alu_sum[ALU_W-1]) begin
                        r_status <= ST_BAD_ADDR;
                        r_state  <= S_DONE;
                    end else begin
                        r_page  <= r_off[PAGE_SHIFT +: CNT_W];
                        r_state <= S_FREE2;
                    end
                end
                S_FREE2: begin
                    r_q     <= div_prod[DIV_SH +: WIDX_W];
                    r_state <= S_FREE3;
                end
                S_FREE3: begin
                    r_bit   <= BIT_W'(r_page - word_first);
                    r_state <= S_FREE4;
                end
                S_FREE4: begin
                    if (free_bit) begin
                        r_free <= r_free + CNT_W'(1);
                    end else begin
                        r_status <= ST_DOUBLE_FREE;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    a_free_within_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_free <= r_total))
        else $error("free page count exceeds total page count");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted beat did not start a sequence");

    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_beat.granted_address != '0)) |->
            (o_out_beat.status == ST_OK))
        else $error("granted address reported with failing status");

endmodule

`default_nettype wire

/* tb/tb_bitmap_page_frame_allocator_top.sv */
// Testbench for the bitmap page frame allocator: directed and random init, alloc and free
// beats, checked field by field against an in-bench first-fit bitmap predictor.
// Depends on bpfa_pkg and bitmap_page_frame_allocator_top.
`default_nettype none

module tb_bitmap_page_frame_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bpfa_pkg::*;

    localparam int          MAX_PAGES   = DEF_MAX_PAGES;
    localparam int          PAGE_SHIFT  = DEF_PAGE_SHIFT;
    localparam logic [63:0] PAGE_BYTES  = 64'd1 << PAGE_SHIFT;
    localparam logic [63:0] PAGE_MASK   = PAGE_BYTES - 64'd1;
    localparam logic [55:0] ADDR_ONES   = '1;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int          HOLD_CYCLES = 600;
    localparam int          PHASES      = 15;
    localparam int          PHASE_BEATS = 102;

    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_REGION_START;
    logic [ADDR_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_beat             in_beat = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_beat            out_beat;

    bitmap_page_frame_allocator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // predictor state
    logic [ADDR_W-1:0]    cfg_start = '0;
    logic [ADDR_W-1:0]    cfg_end = '0;
    logic [MAX_PAGES-1:0] page_used = '0;
    logic [63:0]          base_addr = '0;
    logic [63:0]          limit_addr = '0;
    logic [63:0]          pages_total = '0;
    logic [63:0]          pages_free = '0;

    t_in_beat  pending_beats[$];
    t_out_beat results_due[$];
    int        errors = 0;
    int        snd_idle_pct = 0;
    int        rcv_idle_pct = 0;
    int        hold_asked = 0;
    int        hold_served = 0;
    int        hold_left = 0;

    // stimulus-side view of the region
    logic [63:0] gen_base = '0;
    int          gen_pages = 0;
    int          gen_live = 0;

    function automatic t_out_beat frame_result(input t_in_beat b);
        t_out_beat   r;
        logic [63:0] lo, hi, n, meta, addr, idx;
        logic        found;
        int          i;
        r = '0;
        r.status = ST_OK;
        case (b.op)
            OP_INIT: begin
                lo = ({8'd0, cfg_start} + PAGE_MASK) & ~PAGE_MASK;
                hi = {8'd0, cfg_end} & ~PAGE_MASK;
                page_used = '0;
                if (lo >= hi) begin
                    base_addr = '0;
                    limit_addr = '0;
                    pages_total = '0;
                    pages_free = '0;
                end else begin
                    n = (hi - lo) >> PAGE_SHIFT;
                    if (n > MAX_PAGES) n = MAX_PAGES;
                    base_addr = lo;
                    limit_addr = lo + (n << PAGE_SHIFT);
                    pages_total = n;
                    meta = (((n + 64'd7) / 64'd8) + PAGE_MASK) >> PAGE_SHIFT;
                    if (meta > n) meta = n;
                    for (i = 0; i < meta; i++) page_used[i] = 1'b1;
                    pages_free = n - meta;
                end
            end
            OP_ALLOC: begin
                r.status = ST_NO_FREE;
                found = 1'b0;
                for (i = 0; i < pages_total; i++) begin
                    if (!found && !page_used[i]) begin
                        found = 1'b1;
                        page_used[i] = 1'b1;
                        if (pages_free > 0) pages_free = pages_free - 64'd1;
                        addr = base_addr + (64'(i) << PAGE_SHIFT);
                        r.granted_address = addr[ADDR_W-1:0];
                        r.status = ST_OK;
                    end
                end
            end
            OP_FREE: begin
                addr = {8'd0, b.page_address};
                if (addr < base_addr || addr >= limit_addr || (addr & PAGE_MASK) != 0) begin
                    r.status = ST_BAD_ADDR;
                end else begin
                    idx = (addr - base_addr) >> PAGE_SHIFT;
                    if (idx >= pages_total) begin
                        r.status = ST_BAD_ADDR;
                    end else if (!page_used[idx[11:0]]) begin
                        r.status = ST_DOUBLE_FREE;
                    end else begin
                        page_used[idx[11:0]] = 1'b0;
                        pages_free = pages_free + 64'd1;
                    end
                end
            end
            default: r.status = ST_BAD_ADDR;
        endcase
        r.free_count = pages_free[CNT_OUT_W-1:0];
        r.total_count = pages_total[CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic cmp_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %h, got %h", $time, fname, want, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_beat <= '0;
        end else begin
            if (in_valid && !in_stall) results_due.push_back(frame_result(in_beat));
            if (!in_valid || !in_stall) begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    in_beat <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (results_due.size() == 0) begin
                    $display("%0t mismatch beat: expected none, got %h", $time, out_beat);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    cmp_field("status", want.status, out_beat.status);
                    cmp_field("granted_address", want.granted_address,
                              out_beat.granted_address);
                    cmp_field("free_count", want.free_count, out_beat.free_count);
                    cmp_field("total_count", want.total_count, out_beat.total_count);
                end
            end
            if (hold_served != hold_asked) begin
                hold_served <= hold_asked;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
            end
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ADDR_W-1:0];
    endfunction

    task automatic queue_beat(input logic [OP_W-1:0] op, input logic [63:0] addr);
        t_in_beat b;
        b.op = op;
        b.page_address = addr[ADDR_W-1:0];
        pending_beats.push_back(b);
    endtask

    task automatic queue_init();
        logic [63:0] lo, hi;
        lo = ({8'd0, cfg_start} + PAGE_MASK) & ~PAGE_MASK;
        hi = {8'd0, cfg_end} & ~PAGE_MASK;
        gen_base = (lo < hi) ? lo : 64'd0;
        gen_pages = (lo < hi) ? (((hi - lo) >> PAGE_SHIFT) > MAX_PAGES ? MAX_PAGES
                                 : int'((hi - lo) >> PAGE_SHIFT)) : 0;
        gen_live = 0;
        queue_beat(OP_INIT, {8'd0, rand_addr()});
    endtask

    task automatic wait_drained(input int settle);
        do @(negedge i_clk);
        while (pending_beats.size() != 0 || in_valid || results_due.size() != 0);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == CFG_REGION_START) cfg_start = data;
        else cfg_end = data;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic pick_region();
        logic [63:0] s, e;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            s = {8'd0, rand_addr()} & 64'h007F_FFFF_FFFF_FFFF;
            e = s + (64'($urandom_range(1, 40)) << PAGE_SHIFT) + $urandom_range(0, 4095);
        end else if (r < 75) begin
            s = {8'd0, rand_addr()} & 64'h0000_00FF_FFFF_FFFF;
            e = $urandom_range(0, 1) ? {8'd0, ADDR_ONES}
                : s + (64'($urandom_range(MAX_PAGES, MAX_PAGES + 2000)) << PAGE_SHIFT);
        end else if (r < 85) begin
            s = $urandom_range(0, 3) == 0 ? {8'd0, ADDR_ONES} : {8'd0, rand_addr()};
            e = s - $urandom_range(0, 8000);
        end else begin
            s = {8'd0, rand_addr()} & ~PAGE_MASK & 64'h007F_FFFF_FFFF_FFFF;
            e = s + (64'($urandom_range(1, 2)) << PAGE_SHIFT);
        end
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_REGION_START, s[ADDR_W-1:0]);
            write_reg(CFG_REGION_END, e[ADDR_W-1:0]);
        end else begin
            write_reg(CFG_REGION_END, e[ADDR_W-1:0]);
            write_reg(CFG_REGION_START, s[ADDR_W-1:0]);
        end
    endtask

    task automatic queue_phase(input int count);
        int r, k;
        queue_init();
        for (k = 1; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                queue_beat(OP_ALLOC, {8'd0, rand_addr()});
                if (gen_live < gen_pages) gen_live++;
            end else if (r < 75) begin
                queue_beat(OP_FREE, gen_base +
                           (64'($urandom_range(0, gen_live + 1)) << PAGE_SHIFT));
                if (gen_live > 0) gen_live--;
            end else if (r < 78) begin
                queue_beat(OP_FREE, gen_base + (64'($urandom_range(0, gen_live)) << PAGE_SHIFT)
                           + $urandom_range(1, 4095));
            end else if (r < 81) begin
                queue_beat(OP_FREE, gen_base - (64'($urandom_range(1, 8)) << PAGE_SHIFT));
            end else if (r < 84) begin
                queue_beat(OP_FREE, gen_base +
                           (64'(gen_pages + $urandom_range(0, 3)) << PAGE_SHIFT));
            end else if (r < 87) begin
                queue_beat(OP_FREE, gen_base + (64'($urandom_range(0, 4095)) << PAGE_SHIFT));
            end else if (r < 90) begin
                queue_beat(OP_FREE, {8'd0, rand_addr()});
            end else if (r < 95) begin
                queue_beat(OP_UNUSED, {8'd0, rand_addr()});
            end else begin
                queue_init();
            end
        end
    endtask

    initial begin
        int ph;
        snd_idle_pct = 30;
        rcv_idle_pct = 73;
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;

        // before any init, then a four-page region
        queue_beat(OP_ALLOC, 64'd0);
        queue_beat(OP_FREE, 64'd0);
        queue_beat(OP_UNUSED, 64'd0);
        wait_drained(8);
        write_reg(CFG_REGION_START, 56'h1001);
        write_reg(CFG_REGION_END, 56'h6FFF);
        queue_init();
        repeat (4) queue_beat(OP_ALLOC, 64'd0);
        queue_beat(OP_FREE, 64'h4000);
        queue_beat(OP_FREE, 64'h4000);
        queue_beat(OP_FREE, 64'h4800);
        queue_beat(OP_FREE, 64'h1000);
        queue_beat(OP_FREE, 64'h6000);
        queue_beat(OP_FREE, 64'h2000);
        queue_beat(OP_ALLOC, 64'd0);
        queue_beat(OP_UNUSED, {8'd0, ADDR_ONES});
        wait_drained(8);

        // start aligning past the address range
        write_reg(CFG_REGION_START, ADDR_ONES);
        write_reg(CFG_REGION_END, ADDR_ONES);
        queue_init();
        queue_beat(OP_ALLOC, 64'd0);
        queue_beat(OP_FREE, {8'd0, ADDR_ONES} & ~PAGE_MASK);
        wait_drained(8);

        // oversized region saturates the page count
        write_reg(CFG_REGION_START, '0);
        write_reg(CFG_REGION_END, ADDR_ONES);
        queue_init();
        queue_beat(OP_ALLOC, 64'd0);
        queue_beat(OP_FREE, 64'(MAX_PAGES) << PAGE_SHIFT);
        queue_beat(OP_FREE, 64'(MAX_PAGES - 1) << PAGE_SHIFT);
        queue_beat(OP_FREE, 64'h1000);
        wait_drained(8);

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph < 5) begin
                snd_idle_pct = 30;
                rcv_idle_pct = 73;
            end else if (ph < 10) begin
                snd_idle_pct = 73;
                rcv_idle_pct = 30;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            pick_region();
            queue_phase(PHASE_BEATS);
            if (ph == 3 || ph == 11) begin
                @(posedge i_clk);
                hold_asked <= hold_asked + 1;
            end
            wait_drained(8);
        end

        wait_drained(140);
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* bitmap_page_frame_allocator_top.f */
rtl/core/bpfa_pkg.sv
rtl/core/bpfa_addsub.sv
rtl/core/bpfa_bitmap.sv
rtl/core/bpfa_word_scan.sv
rtl/core/bitmap_page_frame_allocator_top.sv
tb/tb_bitmap_page_frame_allocator_top.sv
